// ===== rtl/core/ccmc_pkg.sv =====
`default_nettype none

package ccmc_pkg;

    localparam int COLOR_W = 4;           // width of one color digit
    localparam int HIST_W  = 11;          // per-column bin width
    localparam int TOTAL_W = 21;          // kept totals, cell count, result

    localparam int NUM_COLORS_DEF  = 10;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [HIST_W-1:0]  HIST_MAX  = {HIST_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // classified cell word, front to back
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               color_ok;   // color lies inside the palette
        logic               close;      // column closes on this cell
        logic               last;       // grid closes on this cell
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/ccmc_front.sv =====
`default_nettype none

module ccmc_front #(
    parameter int NUM_COLORS = ccmc_pkg::NUM_COLORS_DEF
) (
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ccmc_pkg::COLOR_W-1:0] cell_color,
    input  wire logic                         column_end,
    input  wire logic                         grid_end,
    input  wire logic                         q_full,
    output logic                              q_push,
    output ccmc_pkg::item_t                   q_item
);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.color    = cell_color;
        // one extra bit so a full 16-color palette compares correctly
        q_item.color_ok = ({1'b0, cell_color} < (ccmc_pkg::COLOR_W + 1)'(NUM_COLORS));
        q_item.close    = column_end || grid_end;
        q_item.last     = grid_end;
    end

endmodule

`default_nettype wire

// ===== rtl/core/ccmc_queue.sv =====
`default_nettype none

module ccmc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ccmc_pkg::item_t push_item,
    output logic                 full,
    output logic                 head_valid,
    output ccmc_pkg::item_t      head_item,
    input  wire logic            pop
);

    localparam int PW = ccmc_pkg::QUEUE_PTR_W;

    ccmc_pkg::item_t mem_reg [ccmc_pkg::QUEUE_DEPTH];
    ccmc_pkg::item_t mem_next [ccmc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    assign full       = (count_reg == (PW + 1)'(ccmc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        mem_next    = mem_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            mem_next[wr_ptr_reg] = push_item;
            wr_ptr_next          = wr_ptr_reg + PW'(1);
        end
        if (pop)
            rd_ptr_next = rd_ptr_reg + PW'(1);
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (PW + 1)'(1);
            2'b01:   count_next = count_reg - (PW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        mem_reg <= mem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW + 1)'(ccmc_pkg::QUEUE_DEPTH))
        else $error("queue count past depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ===== rtl/core/ccmc_back.sv =====
`default_nettype none

module ccmc_back #(
    parameter int NUM_COLORS = ccmc_pkg::NUM_COLORS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    input  wire ccmc_pkg::item_t               item,
    output logic                               item_ready,
    output logic                               snap_load,
    output logic [ccmc_pkg::TOTAL_W-1:0]       snap_best [NUM_COLORS],
    output logic [ccmc_pkg::TOTAL_W-1:0]       snap_cells,
    input  wire logic                          snap_ready
);

    localparam int TW     = ccmc_pkg::TOTAL_W;
    localparam int HW     = ccmc_pkg::HIST_W;
    localparam int CW     = ccmc_pkg::COLOR_W;
    localparam int LV     = $clog2(NUM_COLORS);
    localparam int LEAVES = 1 << LV;

    logic [HW-1:0] hist_reg [NUM_COLORS];
    logic [HW-1:0] hist_next [NUM_COLORS];
    logic [TW-1:0] best_reg [NUM_COLORS];
    logic [TW-1:0] best_next [NUM_COLORS];
    logic [TW-1:0] cells_reg, cells_next;

    // top-two tree over the kept totals
    logic [TW-1:0] t1 [LV+1][LEAVES];
    logic [TW-1:0] t2 [LV+1][LEAVES];
    logic [CW-1:0] ix [LV+1][LEAVES];
    logic [TW-1:0] top1, top2;
    logic [CW-1:0] top_ix;

    logic [HW-1:0] hist_inc [NUM_COLORS];
    logic [TW:0]   sum_w [NUM_COLORS];
    logic [TW-1:0] best_new [NUM_COLORS];
    logic [TW-1:0] cells_inc;
    logic          pop;

    always_comb
    begin
        for (int l = 0; l <= LV; l++)
        begin
            for (int n = 0; n < LEAVES; n++)
            begin
                t1[l][n] = '0;
                t2[l][n] = '0;
                ix[l][n] = '0;
            end
        end
        for (int n = 0; n < NUM_COLORS; n++)
        begin
            t1[0][n] = best_reg[n];
            ix[0][n] = CW'(n);
        end
        for (int l = 0; l < LV; l++)
        begin
            for (int n = 0; n < (LEAVES >> (l + 1)); n++)
            begin
                if (t1[l][2*n] >= t1[l][2*n+1])
                begin
                    t1[l+1][n] = t1[l][2*n];
                    ix[l+1][n] = ix[l][2*n];
                    t2[l+1][n] = (t2[l][2*n] >= t1[l][2*n+1]) ? t2[l][2*n] : t1[l][2*n+1];
                end
                else
                begin
                    t1[l+1][n] = t1[l][2*n+1];
                    ix[l+1][n] = ix[l][2*n+1];
                    t2[l+1][n] = (t2[l][2*n+1] >= t1[l][2*n]) ? t2[l][2*n+1] : t1[l][2*n];
                end
            end
        end
        top1   = t1[LV][0];
        top2   = t2[LV][0];
        top_ix = ix[LV][0];
    end

    always_comb
    begin
        for (int c = 0; c < NUM_COLORS; c++)
        begin
            hist_inc[c] = hist_reg[c] + HW'(item.color_ok && (item.color == CW'(c))
                                            && (hist_reg[c] != ccmc_pkg::HIST_MAX));
            sum_w[c]    = {1'b0, ((top_ix == CW'(c)) ? top2 : top1)} + (TW + 1)'(hist_inc[c]);
            // carry out means past the top of the total range
            best_new[c] = sum_w[c][TW] ? ccmc_pkg::TOTAL_MAX : sum_w[c][TW-1:0];
        end
        cells_inc = (cells_reg == ccmc_pkg::TOTAL_MAX) ? cells_reg : cells_reg + TW'(1);
    end

    assign item_ready = !item.last || snap_ready;
    assign pop        = item_valid && item_ready;
    assign snap_load  = pop && item.last;
    assign snap_best  = best_new;
    assign snap_cells = cells_inc;

    always_comb
    begin
        hist_next  = hist_reg;
        best_next  = best_reg;
        cells_next = cells_reg;
        if (pop)
        begin
            priority if (item.last)
            begin
                for (int c = 0; c < NUM_COLORS; c++)
                begin
                    hist_next[c] = '0;
                    best_next[c] = '0;
                end
                cells_next = '0;
            end
            else if (item.close)
            begin
                for (int c = 0; c < NUM_COLORS; c++)
                    hist_next[c] = '0;
                best_next  = best_new;
                cells_next = cells_inc;
            end
            else
            begin
                hist_next  = hist_inc;
                cells_next = cells_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                hist_reg[c] <= '0;
                best_reg[c] <= '0;
            end
            cells_reg <= '0;
        end
        else
        begin
            hist_reg  <= hist_next;
            best_reg  <= best_next;
            cells_reg <= cells_next;
        end
    end

    a_grid_clears: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |=> (cells_reg == '0) && (best_reg[0] == '0) && (hist_reg[0] == '0))
        else $error("state not cleared after grid end");

endmodule

`default_nettype wire

// ===== rtl/core/ccmc_result.sv =====
`default_nettype none

module ccmc_result #(
    parameter int NUM_COLORS = ccmc_pkg::NUM_COLORS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          snap_load,
    input  wire logic [ccmc_pkg::TOTAL_W-1:0]  snap_best [NUM_COLORS],
    input  wire logic [ccmc_pkg::TOTAL_W-1:0]  snap_cells,
    output logic                               snap_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ccmc_pkg::TOTAL_W-1:0]       min_changes
);

    localparam int TW     = ccmc_pkg::TOTAL_W;
    localparam int LV     = $clog2(NUM_COLORS);
    localparam int LEAVES = 1 << LV;

    logic          snap_valid_reg, snap_valid_next;
    logic [TW-1:0] snap_best_reg [NUM_COLORS];
    logic [TW-1:0] snap_best_next [NUM_COLORS];
    logic [TW-1:0] snap_cells_reg, snap_cells_next;
    logic          out_valid_reg, out_valid_next;
    logic [TW-1:0] min_changes_reg, min_changes_next;

    logic [TW-1:0] mx [LV+1][LEAVES];
    logic [TW-1:0] best;
    logic          move;

    // max tree over the final totals
    always_comb
    begin
        for (int l = 0; l <= LV; l++)
        begin
            for (int n = 0; n < LEAVES; n++)
                mx[l][n] = '0;
        end
        for (int n = 0; n < NUM_COLORS; n++)
            mx[0][n] = snap_best_reg[n];
        for (int l = 0; l < LV; l++)
        begin
            for (int n = 0; n < (LEAVES >> (l + 1)); n++)
                mx[l+1][n] = (mx[l][2*n] >= mx[l][2*n+1]) ? mx[l][2*n] : mx[l][2*n+1];
        end
        best = mx[LV][0];
    end

    assign move       = snap_valid_reg && (!out_valid_reg || out_ready);
    assign snap_ready = !snap_valid_reg || move;

    always_comb
    begin
        snap_valid_next  = snap_valid_reg;
        snap_best_next   = snap_best_reg;
        snap_cells_next  = snap_cells_reg;
        out_valid_next   = out_valid_reg;
        min_changes_next = min_changes_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (move)
        begin
            snap_valid_next  = 1'b0;
            out_valid_next   = 1'b1;
            min_changes_next = (snap_cells_reg > best) ? snap_cells_reg - best : '0;
        end
        if (snap_load)
        begin
            snap_valid_next = 1'b1;
            snap_best_next  = snap_best;
            snap_cells_next = snap_cells;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_best_reg   <= snap_best_next;
        snap_cells_reg  <= snap_cells_next;
        min_changes_reg <= min_changes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign min_changes = min_changes_reg;

    a_snap_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && !snap_ready) |=> snap_valid_reg && $stable(snap_cells_reg))
        else $error("snapshot lost while result stalled");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |-> snap_ready)
        else $error("snapshot overwritten");

endmodule

`default_nettype wire

// ===== rtl/core/column_coloring_min_changes_dp_core.sv =====
// Column coloring, fewest changes (paint-house DP) core.
// Input channel: in_valid/in_ready carry one grid cell per word: cell_color,
// column_end (last cell of a column) and grid_end (last cell of the grid,
// also closes the column). Cells come column by column.
// Output channel: out_valid/out_ready carry one min_changes word per grid,
// the cell count minus the best kept total over all colors.
// Throughput: one cell per cycle while in_ready is high, including column and
// grid closes; the NUM_COLORS-way top-two update is a parallel tree in the
// back end, so a column may be a single cell long.
// A grid_end cell is written into the queue; at the queue head it loads the
// final snapshot register, and a max tree over that snapshot then fills the
// output register.
// A four-word queue sits between the classifying front end and the DP back
// end. When out_ready is low the output register and one final snapshot
// hold; a third grid_end then waits in the queue while later cells fill it,
// after which in_ready drops.
// Reset (rst_n, async low) empties the queue and clears the histogram, kept
// totals and cell count; after every grid end that state clears again.
`default_nettype none

module column_coloring_min_changes_dp_core #(
    parameter int NUM_COLORS = ccmc_pkg::NUM_COLORS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ccmc_pkg::COLOR_W-1:0] cell_color,
    input  wire logic                         column_end,
    input  wire logic                         grid_end,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ccmc_pkg::TOTAL_W-1:0]      min_changes
);

    logic                         q_full;
    logic                         q_push;
    ccmc_pkg::item_t              q_item;
    logic                         head_valid;
    ccmc_pkg::item_t              head_item;
    logic                         head_ready;
    logic                         head_pop;
    logic                         snap_load;
    logic                         snap_ready;
    logic [ccmc_pkg::TOTAL_W-1:0] snap_best [NUM_COLORS];
    logic [ccmc_pkg::TOTAL_W-1:0] snap_cells;

    // front: palette check and close flags
    ccmc_front #(
        .NUM_COLORS (NUM_COLORS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_color (cell_color),
        .column_end (column_end),
        .grid_end   (grid_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    ccmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (head_pop)
    );

    // back: histogram, kept totals, cell count
    ccmc_back #(
        .NUM_COLORS (NUM_COLORS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (head_valid),
        .item       (head_item),
        .item_ready (head_ready),
        .snap_load  (snap_load),
        .snap_best  (snap_best),
        .snap_cells (snap_cells),
        .snap_ready (snap_ready)
    );

    assign head_pop = head_valid && head_ready;

    // final max, subtract, output register
    ccmc_result #(
        .NUM_COLORS (NUM_COLORS)
    ) u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap_load   (snap_load),
        .snap_best   (snap_best),
        .snap_cells  (snap_cells),
        .snap_ready  (snap_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .min_changes (min_changes)
    );

endmodule

`default_nettype wire
